FILE: src/fpa_pkg.sv
// Package for the binary32 adder: field constants and helpers.
// No dependencies.
package fpa_pkg;
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [30:0] InfMag   = 31'h7F80_0000;
  localparam logic [7:0]  ExpMax   = 8'hFF;

  // count leading zeros of a 27-bit magnitude (27 when zero)
  function automatic logic [4:0] clz27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (v[i] && !found) begin
        n = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage

FILE: src/fp32_adder_core.sv
// Binary32 adder, round to nearest even.
// The result strobe follows the start transfer through the input and result registers.
// Throughput: one addition per cycle; busy is always low.
// Reset: rst_ni asynchronous active low clears the strobe pipeline; no other state.
// The receiver cannot stall: each result shows for exactly one cycle.
module fp32_adder_core
  import fpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] sum_o
);
  logic        vin_q, vout_q;
  logic [31:0] a_q, b_q, sum_q, sum_d;

  assign busy   = 1'b0;
  assign done_o = vout_q;
  assign sum_o  = sum_q;

  // strobe pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q  <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      vin_q  <= start;
      vout_q <= vin_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      a_q <= operand_a_i;
      b_q <= operand_b_i;
    end
    if (vin_q) sum_q <= sum_d;
  end

  // single-pass add datapath
  logic        sa, sb, sbig, ssml, nan_a, nan_b, inf_a, inf_b, swap;
  logic [30:0] ma, mb;
  logic [31:0] big, sml;
  logic [7:0]  eb, es, d;
  logic [26:0] mbig, msml, sh, lostmask;
  logic [27:0] m;
  logic [26:0] mn;
  logic [9:0]  e;
  logic [4:0]  lz, ls;
  logic [23:0] mr0;
  logic [24:0] mr;
  logic [2:0]  rem;

  always_comb begin
    sa = a_q[31]; sb = b_q[31];
    ma = a_q[30:0]; mb = b_q[30:0];
    nan_a = ma > InfMag; nan_b = mb > InfMag;
    inf_a = ma == InfMag; inf_b = mb == InfMag;
    swap = ma < mb;
    big = swap ? b_q : a_q;
    sml = swap ? a_q : b_q;
    sbig = big[31]; ssml = sml[31];
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mbig = {big[30:23] != 8'd0, big[22:0], 3'b000};
    msml = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    d = eb - es;
    // align with sticky
    if (d >= 8'd27) begin
      lostmask = '0;
      sh = {26'd0, msml != 27'd0};
    end else begin
      lostmask = ~(27'h7FF_FFFF << d[4:0]);
      sh = (msml >> d[4:0]) | {26'd0, (msml & lostmask) != 27'd0};
    end
    m = (sbig == ssml) ? {1'b0, mbig} + {1'b0, sh} : {1'b0, mbig} - {1'b0, sh};
    e = {2'b0, eb};
    // normalize
    lz = clz27(m[26:0]);
    if (m[27]) begin
      mn = m[27:1] | {26'd0, m[0]};
      e = e + 10'd1;
      ls = 5'd0;
    end else begin
      ls = ({5'd0, lz} < e - 10'd1) ? lz : 5'(e - 10'd1);
      mn = m[26:0] << ls;
      e = e - {5'd0, ls};
    end
    // round to nearest even
    mr0 = mn[26:3];
    rem = mn[2:0];
    mr = {1'b0, mr0} + {24'd0, (rem > 3'd4) || (rem == 3'd4 && mr0[0])};
    if (mr[24]) begin
      mr = mr >> 1;
      e = e + 10'd1;
    end
    // specials and packing
    priority if (nan_a || nan_b) sum_d = CanonNan;
    else if (inf_a && inf_b)     sum_d = (sa == sb) ? a_q : CanonNan;
    else if (inf_a)              sum_d = a_q;
    else if (inf_b)              sum_d = b_q;
    else if (m == 28'd0)         sum_d = {(sbig == ssml) & sbig, 31'd0};
    else if (e >= {2'b0, ExpMax}) sum_d = {sbig, InfMag};
    else sum_d = {sbig, mr[23] ? e[7:0] : 8'd0, mr[22:0]};
  end
endmodule

FILE: src/fpa_checker.sv
// Port-level checker for fp32_adder_core, bound into every fp32_adder_core instance.
// Depends on fpa_pkg.
module fpa_checker
  import fpa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] operand_a_i,
  input logic [31:0] operand_b_i,
  input logic [31:0] sum_o
);
  // every transfer gives a result, and every result follows a transfer
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 done_o) else $error("missing result");
  a_spur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 2)) else $error("spurious result");
  // NaN in gives canonical NaN out
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && ((operand_a_i[30:0] > InfMag) || (operand_b_i[30:0] > InfMag))
    |-> ##2 sum_o == CanonNan)
    else $error("nan not canonical");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
endmodule

bind fp32_adder_core fpa_checker u_fpa_checker (.*);
